// File: src/bbkk_pkg.sv
// ----------------------------------------------------------------------------
// bbkk_pkg
// shared types and constants of the bounded best-k keeper
// ----------------------------------------------------------------------------
package bbkk_pkg;

  localparam int SCORE_W = 32;
  localparam int TAG_W   = 32;
  localparam int RANK_W  = 4;
  localparam int COUNT_W = 5;
  localparam int CAP_W   = 5;

  // reset values of the configuration registers
  localparam logic [CAP_W-1:0]          CAP_RESET = 5'd16;
  localparam logic signed [SCORE_W-1:0] THR_RESET = 32'sh7FFF_FFFF;

  // item command codes
  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // configuration register indexes
  typedef enum logic {
    REG_CAPACITY  = 1'b0,
    REG_THRESHOLD = 1'b1
  } cfg_reg_t;

  // controller to datapath
  typedef struct packed {
    logic latch;     // take the input item into the item registers
    logic rd_rank;   // read the entry at the requested rank
    logic start;     // begin an insertion at the last kept position
    logic shift;     // move the entry just read one position down
    logic place;     // write the candidate at the current position
    logic load_out;  // load the result registers
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_read;   // the offered transaction is a read
    logic offer_ok;  // candidate beats the threshold
    logic n_zero;    // insertion starts at position zero
    logic sh_less;   // candidate beats the entry just read
    logic idx_one;   // current position is one
  } dp_status_t;

endpackage

// File: src/bbkk_datapath.sv
// ----------------------------------------------------------------------------
// bbkk_datapath
// entry memory, count, threshold, configuration and result registers
// ----------------------------------------------------------------------------
module bbkk_datapath
  import bbkk_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic                      command,
  input  logic signed [SCORE_W-1:0] cand_score,
  input  logic [TAG_W-1:0]          cand_tag,
  input  logic [RANK_W-1:0]         read_rank,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [31:0]               cfg_data,
  output logic                      accepted,
  output logic [COUNT_W-1:0]        stored_count,
  output logic signed [SCORE_W-1:0] threshold_now,
  output logic                      entry_valid,
  output logic signed [SCORE_W-1:0] entry_score,
  output logic [TAG_W-1:0]          entry_tag
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic signed [SCORE_W-1:0] mem_score [MAX_ENTRIES];
  logic [TAG_W-1:0]          mem_tag   [MAX_ENTRIES];

  logic                      item_cmd;
  logic signed [SCORE_W-1:0] item_score;
  logic [TAG_W-1:0]          item_tag;
  logic [RANK_W-1:0]         item_rank;
  logic [CAP_W-1:0]          cap;
  logic signed [SCORE_W-1:0] thr;
  logic [CW-1:0]             held;
  logic [AW-1:0]             idx;
  logic [AW-1:0]             last_idx;
  logic                      acc;
  logic signed [SCORE_W-1:0] rd_score;
  logic [TAG_W-1:0]          rd_tag;

  logic [7:0]                cap8;
  logic [7:0]                eff8;
  logic [7:0]                held8;
  logic [7:0]                n8;
  logic [7:0]                rank8;
  logic [7:0]                item_rank8;
  logic                      full;
  logic [AW-1:0]             n_idx;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic signed [SCORE_W-1:0] wr_score;
  logic [TAG_W-1:0]          wr_tag;

  // effective capacity: zero counts as one, saturate at the built depth
  always_comb begin
    cap8  = {3'b000, cap};
    held8 = 8'(held);
    if (cap8 == 8'd0) begin
      eff8 = 8'd1;
    end else if (cap8 > 8'(MAX_ENTRIES)) begin
      eff8 = 8'(MAX_ENTRIES);
    end else begin
      eff8 = cap8;
    end
    full  = (held8 >= eff8);
    n8    = full ? (held8 - 8'd1) : held8;
    n_idx = n8[AW-1:0];
  end

  assign rank8      = {4'b0000, read_rank};
  assign item_rank8 = {4'b0000, item_rank};

  assign status.in_read  = (command == CMD_READ);
  assign status.offer_ok = (item_score < thr);
  assign status.n_zero   = (n8 == 8'd0);
  assign status.sh_less  = (item_score < rd_score);
  assign status.idx_one  = (idx == AW'(1));

  // read port select
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx - AW'(2);
    if (cmd.rd_rank) begin
      rd_en   = 1'b1;
      rd_addr = rank8[AW-1:0];
    end else if (cmd.start) begin
      rd_en   = (n8 != 8'd0);
      rd_addr = n_idx - AW'(1);
    end else if (cmd.shift) begin
      rd_en   = (idx != AW'(1));
      rd_addr = idx - AW'(2);
    end
  end

  // write port: shifted entry or the candidate itself
  assign wr_en    = cmd.shift | cmd.place;
  assign wr_addr  = idx;
  assign wr_score = cmd.shift ? rd_score : item_score;
  assign wr_tag   = cmd.shift ? rd_tag : item_tag;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_score[wr_addr] <= wr_score;
      mem_tag[wr_addr]   <= wr_tag;
    end
    if (rd_en) begin
      rd_score <= mem_score[rd_addr];
      rd_tag   <= mem_tag[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= CAP_RESET;
      thr  <= THR_RESET;
      held <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_CAPACITY) begin
        cap <= cfg_data[CAP_W-1:0];
      end
      if (cfg_we && cfg_index == REG_THRESHOLD) begin
        thr <= cfg_data;
      end else if (wr_en && wr_addr == last_idx) begin
        // whatever lands in the last kept position is the new worst score
        thr <= wr_score;
      end
      if (cmd.start && !full) begin
        held <= held + CW'(1);
      end
    end
  end

  // item and position registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd   <= command;
      item_score <= cand_score;
      item_tag   <= cand_tag;
      item_rank  <= read_rank;
      acc        <= 1'b0;
    end else if (cmd.start) begin
      acc <= 1'b1;
    end
    if (cmd.start) begin
      idx      <= n_idx;
      last_idx <= n_idx;
    end else if (cmd.shift) begin
      idx <= idx - AW'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      accepted      <= acc;
      stored_count  <= held8[COUNT_W-1:0];
      threshold_now <= thr;
      if (item_cmd == CMD_READ && item_rank8 < held8) begin
        entry_valid <= 1'b1;
        entry_score <= rd_score;
        entry_tag   <= rd_tag;
      end else begin
        entry_valid <= 1'b0;
        entry_score <= '0;
        entry_tag   <= '0;
      end
    end
  end

endmodule

// File: src/bbkk_ctrl.sv
// ----------------------------------------------------------------------------
// bbkk_ctrl
// sequencer for offers, insertion shifts, reads and result hand-off
// ----------------------------------------------------------------------------
module bbkk_ctrl
  import bbkk_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_PLACE  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (status.in_read) begin
            cmd.rd_rank = 1'b1;
            state_next  = S_RESULT;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (status.offer_ok) begin
          cmd.start  = 1'b1;
          state_next = status.n_zero ? S_PLACE : S_SHIFT;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SHIFT: begin
        if (status.sh_less) begin
          cmd.shift  = 1'b1;
          state_next = status.idx_one ? S_PLACE : S_SHIFT;
        end else begin
          cmd.place  = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: src/bounded_best_k_keeper_top.sv
// ----------------------------------------------------------------------------
// bounded_best_k_keeper_top
// keeps the lowest-score (score, tag) entries sorted best first, up to the
// configured capacity, and answers rank reads
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  -------------------------------------------
//  in       in_valid / in_ready     command, cand_score, cand_tag, read_rank
//  out      out_valid / out_ready   accepted, stored_count, threshold_now,
//                                   entry_valid, entry_score, entry_tag
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  a read goes straight to the result, a rejected offer passes a check first,
//  and an accepted offer also moves each displaced entry down; the entry memory
//  has one write port, so insertion moves a single entry per cycle
//  rst is synchronous: count cleared, capacity 16, threshold at maximum
//  the result sits in an output register, so a new transaction is taken
//  while the previous result waits; only the final hand-off waits on out_ready
//  cfg_ready is always high; writes belong in idle time
//
module bounded_best_k_keeper_top
  import bbkk_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  // input transaction
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      command,
  input  logic signed [SCORE_W-1:0] cand_score,
  input  logic [TAG_W-1:0]          cand_tag,
  input  logic [RANK_W-1:0]         read_rank,
  // result transaction
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      accepted,
  output logic [COUNT_W-1:0]        stored_count,
  output logic signed [SCORE_W-1:0] threshold_now,
  output logic                      entry_valid,
  output logic signed [SCORE_W-1:0] entry_score,
  output logic [TAG_W-1:0]          entry_tag,
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [31:0]               cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // sequencer: walks the insertion from the last kept position upward
  bbkk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // entry memory, count, threshold and result registers
  bbkk_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .command       (command),
    .cand_score    (cand_score),
    .cand_tag      (cand_tag),
    .read_rank     (read_rank),
    .cfg_we        (cfg_valid & cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .accepted      (accepted),
    .stored_count  (stored_count),
    .threshold_now (threshold_now),
    .entry_valid   (entry_valid),
    .entry_score   (entry_score),
    .entry_tag     (entry_tag)
  );

endmodule

// File: bench/keeper_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keeper_checker
// predicts every result of the best-k keeper from the accepted transactions
// and register writes, and compares each result field by field
// ----------------------------------------------------------------------------
module keeper_checker
  import bbkk_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      command,
  input  logic signed [SCORE_W-1:0] cand_score,
  input  logic [TAG_W-1:0]          cand_tag,
  input  logic [RANK_W-1:0]         read_rank,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      accepted,
  input  logic [COUNT_W-1:0]        stored_count,
  input  logic signed [SCORE_W-1:0] threshold_now,
  input  logic                      entry_valid,
  input  logic signed [SCORE_W-1:0] entry_score,
  input  logic [TAG_W-1:0]          entry_tag,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [31:0]               cfg_data,
  output int                        mismatches,
  output int                        awaiting
);

  typedef struct packed {
    logic               accepted;
    logic [COUNT_W-1:0] count;
    logic [SCORE_W-1:0] thr;
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
  } keeper_result_t;

  // shadow of the sorted store, best first
  logic signed [SCORE_W-1:0] kept_score [MAX_ENTRIES];
  logic [TAG_W-1:0]          kept_tag   [MAX_ENTRIES];
  int                        kept_count;
  logic signed [SCORE_W-1:0] bar;
  logic [CAP_W-1:0]          cap_setting;

  keeper_result_t            expected_results [$];
  int                        result_no;

  function automatic keeper_result_t keeper_predict(input logic cmd,
                                                    input logic signed [SCORE_W-1:0] sc,
                                                    input logic [TAG_W-1:0] tg,
                                                    input logic [RANK_W-1:0] rk);
    keeper_result_t r;
    int             lim;
    int             n;
    int             pos;
    int             i;
    r = '0;
    if (cmd == CMD_OFFER) begin
      if (sc < bar) begin
        lim = (cap_setting == 0) ? 1 :
              (int'(cap_setting) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_setting);
        n = kept_count;
        // full (or capacity lowered under the count): the worst entry drops out
        if (n >= lim) n = n - 1;
        else kept_count = n + 1;
        pos = 0;
        // equal scores: the newcomer goes behind
        while (pos < n && !(sc < kept_score[pos])) pos++;
        for (i = n; i > pos; i--) begin
          kept_score[i] = kept_score[i-1];
          kept_tag[i]   = kept_tag[i-1];
        end
        kept_score[pos] = sc;
        kept_tag[pos]   = tg;
        bar = kept_score[kept_count-1];
        r.accepted = 1'b1;
      end
    end else if (int'(rk) < kept_count && int'(rk) < MAX_ENTRIES) begin
      r.valid = 1'b1;
      r.score = kept_score[rk];
      r.tag   = kept_tag[rk];
    end
    r.count = COUNT_W'(kept_count);
    r.thr   = bar;
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  always @(posedge clk) begin
    keeper_result_t want;
    keeper_result_t pred;
    if (rst) begin
      kept_count  = 0;
      bar         = THR_RESET;
      cap_setting = CAP_RESET;
      result_no   = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result %0d with no transaction waiting", result_no));
        end else begin
          want = expected_results.pop_front();
          if (accepted !== want.accepted)
            flag_mismatch($sformatf("result %0d accepted %b, want %b",
                                    result_no, accepted, want.accepted));
          if (stored_count !== want.count)
            flag_mismatch($sformatf("result %0d stored_count %0d, want %0d",
                                    result_no, stored_count, want.count));
          if (threshold_now !== want.thr)
            flag_mismatch($sformatf("result %0d threshold_now %h, want %h",
                                    result_no, threshold_now, want.thr));
          if (entry_valid !== want.valid)
            flag_mismatch($sformatf("result %0d entry_valid %b, want %b",
                                    result_no, entry_valid, want.valid));
          if (entry_score !== want.score)
            flag_mismatch($sformatf("result %0d entry_score %h, want %h",
                                    result_no, entry_score, want.score));
          if (entry_tag !== want.tag)
            flag_mismatch($sformatf("result %0d entry_tag %h, want %h",
                                    result_no, entry_tag, want.tag));
        end
        result_no++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CAPACITY:  cap_setting = cfg_data[CAP_W-1:0];
          REG_THRESHOLD: bar = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pred = keeper_predict(command, cand_score, cand_tag, read_rank);
        // append to the tail of the expected queue
        expected_results = {expected_results, pred};
      end
    end
    awaiting <= expected_results.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives the best-k keeper with directed and random offers and rank reads
// across several capacity and threshold settings; the checker beside the
// block predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;
  import bbkk_pkg::*;

  localparam int MAX_ENTRIES    = 16;
  localparam int ITEMS_PER_SET  = 100;
  localparam int RX_HOLD_CYCLES = 400;   // long receiver stall, fills the block
  localparam int SETTLE_CYCLES  = 4;     // idle margin before a register write
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction at all

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      command = CMD_OFFER;
  logic signed [SCORE_W-1:0] cand_score = '0;
  logic [TAG_W-1:0]          cand_tag = '0;
  logic [RANK_W-1:0]         read_rank = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      accepted;
  logic [COUNT_W-1:0]        stored_count;
  logic signed [SCORE_W-1:0] threshold_now;
  logic                      entry_valid;
  logic signed [SCORE_W-1:0] entry_score;
  logic [TAG_W-1:0]          entry_tag;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic                      cfg_index = REG_CAPACITY;
  logic [31:0]               cfg_data = '0;

  int mismatches;
  int awaiting;
  int idle_cycles = 0;

  // shared between the stimulus process and the receiver process
  bit quiet       = 1'b0;  // no idling on either side
  bit rx_hold_req = 1'b0;  // ask the receiver for one long stall

  // capacity per random set: extremes, zero (counts as one) and 31 (saturates)
  int cap_plan [9] = '{16, 1, 5, 0, 31, 8, 2, 16, 16};

  bounded_best_k_keeper_top #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .cand_score    (cand_score),
    .cand_tag      (cand_tag),
    .read_rank     (read_rank),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .stored_count  (stored_count),
    .threshold_now (threshold_now),
    .entry_valid   (entry_valid),
    .entry_score   (entry_score),
    .entry_tag     (entry_tag),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  keeper_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .cand_score    (cand_score),
    .cand_tag      (cand_tag),
    .read_rank     (read_rank),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .stored_count  (stored_count),
    .threshold_now (threshold_now),
    .entry_valid   (entry_valid),
    .entry_score   (entry_score),
    .entry_tag     (entry_tag),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .awaiting      (awaiting)
  );

  always #1 clk = ~clk;

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, awaiting);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, one long hold on request, none when quiet
  initial begin : rx_side
    int n;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one input transaction; returns at the edge where it is taken
  task automatic send_item(input logic cmd, input logic signed [SCORE_W-1:0] sc,
                           input logic [TAG_W-1:0] tg, input logic [RANK_W-1:0] rk);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 14);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    cand_score <= sc;
    cand_tag   <= tg;
    read_rank  <= rk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int                        k;
    int                        p;
    logic                      cmd;
    logic signed [SCORE_W-1:0] sc;
    logic [RANK_W-1:0]         rk;
    logic [31:0]               val;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty store, then fill at the reset capacity of 16
    send_item(CMD_READ, $urandom, $urandom, 4'd0);
    send_item(CMD_READ, $urandom, $urandom, 4'd15);
    // equal to the reset threshold: not strictly below, so rejected
    send_item(CMD_OFFER, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 4'd15);
    send_item(CMD_OFFER, 32'sh7FFF_FFFE, 32'hFFFF_FFFF, 4'd0);
    send_item(CMD_OFFER, 32'sh0, 32'h0, 4'd0);
    // same score again: lands after the earlier zero
    send_item(CMD_OFFER, 32'sh0, 32'h1, 4'd0);
    send_item(CMD_OFFER, -32'sh1, 32'h2, 4'd0);
    send_item(CMD_OFFER, 32'sh8000_0000, 32'h3, 4'd0);
    // equal to the worst stored score: rejected
    send_item(CMD_OFFER, 32'sh7FFF_FFFE, 32'h4, 4'd0);
    // ranks 0..4 held, rank 5 past the count
    for (k = 0; k < 6; k++) send_item(CMD_READ, $urandom, $urandom, k[RANK_W-1:0]);

    // capacity lowered under the five held entries: store counts as full
    drain_results();
    write_reg(REG_CAPACITY, 32'd2);
    send_item(CMD_OFFER, 32'sh0001_0000, 32'h5, 4'd0);
    send_item(CMD_READ, $urandom, $urandom, 4'd4);

    // threshold at the minimum: nothing can be taken
    drain_results();
    write_reg(REG_THRESHOLD, 32'h8000_0000);
    send_item(CMD_OFFER, 32'sh8000_0000, 32'h6, 4'd0);
    send_item(CMD_OFFER, 32'sh8000_0001, 32'h7, 4'd0);

    // capacity zero with junk in the upper data bits counts as one
    drain_results();
    write_reg(REG_CAPACITY, 32'hFFFF_FFE0);
    write_reg(REG_THRESHOLD, 32'h7FFF_FFFF);
    send_item(CMD_OFFER, 32'sh5, 32'h8, 4'd0);

    // capacity 31 saturates to the built depth, store grows again
    drain_results();
    write_reg(REG_CAPACITY, 32'd31);
    send_item(CMD_OFFER, 32'sh6, 32'h9, 4'd0);
    send_item(CMD_OFFER, -32'sh2, 32'hA, 4'd0);

    // random sets, one capacity and threshold setting each
    for (p = 0; p < 9; p++) begin
      drain_results();
      val = $urandom;
      val[CAP_W-1:0] = cap_plan[p][CAP_W-1:0];
      write_reg(REG_CAPACITY, val);
      write_reg(REG_THRESHOLD, (p % 3 == 0) ? 32'h7FFF_FFFF : $urandom);
      if (p == 4) rx_hold_req = 1'b1;
      if (p == 8) quiet = 1'b1;
      repeat (ITEMS_PER_SET) begin
        cmd = ($urandom_range(0, 9) < 3) ? CMD_READ : CMD_OFFER;
        // mostly a narrow window so that ties and replacements are common
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: sc = $signed($urandom_range(0, 96)) - 48;
          8, 9, 10, 11:           sc = $urandom;
          12: begin
            case ($urandom_range(0, 3))
              0:       sc = 32'sh8000_0000;
              1:       sc = 32'sh7FFF_FFFF;
              2:       sc = 32'sh8000_0001;
              default: sc = 32'sh7FFF_FFFE;
            endcase
          end
          default: sc = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
        endcase
        rk = $urandom_range(0, 1) ? RANK_W'($urandom_range(0, 15))
                                  : RANK_W'($urandom_range(0, 3));
        send_item(cmd, sc, $urandom, rk);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
